### hw/rtl/atan2op_pkg.sv
`timescale 1ns / 1ps
package atan2op_pkg;

  localparam int unsigned ANGLE_WIDTH = 16;
  localparam int unsigned Q_WIDTH     = 31;   // t is Q1.30, 0 .. 2^30
  localparam int unsigned DIV_STEPS   = 31;   // one quotient bit per stage
  localparam int unsigned HORNER_STEPS = 9;   // eight t2 steps, then times t
  localparam int unsigned ACC_WIDTH   = 34;   // signed Q30 up to +/- pi

  localparam logic signed [31:0] COEF_0 = 32'sd3077586;
  localparam logic [30:0] Q30_HALF = 31'd536870912;
  localparam logic signed [ACC_WIDTH-1:0] Q30_PI     = 34'sd3373259426;
  localparam logic signed [ACC_WIDTH-1:0] Q30_HALFPI = 34'sd1686629713;
  localparam logic signed [ANGLE_WIDTH-1:0] Q13_PI     = 16'sd25736;
  localparam logic signed [ANGLE_WIDTH-1:0] Q13_HALFPI = 16'sd12868;

  // addend after each product with t2, last entry is the constant term 1.0
  localparam logic signed [31:0] HORNER_ADD [0:7] = '{
    -32'sd17357828, 32'sd46073848, -32'sd80841632, 32'sd114420760,
    -32'sd152566896, 32'sd214679120, -32'sd357911936, 32'sd1073741824
  };

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic flip;
    logic special;
    logic signed [ANGLE_WIDTH-1:0] special_angle;
  } ctrl_t;

  // signed Q30 times unsigned Q30, rounded to nearest, ties away from zero
  function automatic logic signed [31:0] mul_q30(logic signed [31:0] r,
                                                 logic [Q_WIDTH-1:0] u);
    logic [31:0] a;
    logic [62:0] p;
    logic [32:0] q;
    a = r[31] ? 32'(-r) : 32'(r);
    p = 63'(a) * 63'(u);
    q = 33'((p + 63'(Q30_HALF)) >> 30);
    return r[31] ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

endpackage

### hw/rtl/atan2op_div.sv
`timescale 1ns / 1ps
module atan2op_div #(
  parameter int unsigned W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [W-1:0]                         lo,
  input  logic [W-1:0]                         hi,
  input  atan2op_pkg::ctrl_t                   in_ctrl,
  output logic                                 out_valid,
  output logic [atan2op_pkg::Q_WIDTH-1:0]      quo_out,
  output atan2op_pkg::ctrl_t                   out_ctrl
);

  localparam int unsigned N = atan2op_pkg::DIV_STEPS;

  logic                             vld  [0:N-1];
  logic [W-1:0]                     rem  [0:N-1];
  logic [W-1:0]                     dvs  [0:N-1];
  logic [atan2op_pkg::Q_WIDTH-1:0]  quo  [0:N-1];
  atan2op_pkg::ctrl_t               ctl  [0:N-1];

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [W:0]                       trial;
    logic [W-1:0]                     d_in;
    logic [atan2op_pkg::Q_WIDTH-1:0]  q_in;
    logic                             v_in;
    atan2op_pkg::ctrl_t               c_in;
    logic                             bit_set;

    if (s == 0) begin : g_first
      assign trial = {1'b0, lo};
      assign d_in  = hi;
      assign q_in  = '0;
      assign v_in  = in_valid;
      assign c_in  = in_ctrl;
    end else begin : g_next
      assign trial = {rem[s-1], 1'b0};
      assign d_in  = dvs[s-1];
      assign q_in  = quo[s-1];
      assign v_in  = vld[s-1];
      assign c_in  = ctl[s-1];
    end

    assign bit_set = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
      if (en) begin
        rem[s] <= bit_set ? W'(trial - {1'b0, d_in}) : W'(trial);
        dvs[s] <= d_in;
        quo[s] <= {q_in[atan2op_pkg::Q_WIDTH-2:0], bit_set};
        ctl[s] <= c_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo_out   = quo[N-1];
  assign out_ctrl  = ctl[N-1];

endmodule

### hw/rtl/atan2op_poly.sv
`timescale 1ns / 1ps
module atan2op_poly (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [atan2op_pkg::Q_WIDTH-1:0]  t,
  input  atan2op_pkg::ctrl_t               in_ctrl,
  output logic                             out_valid,
  output logic signed [31:0]               r_out,
  output atan2op_pkg::ctrl_t               out_ctrl
);

  localparam int unsigned N = atan2op_pkg::HORNER_STEPS;

  // squaring stage
  logic                             sq_vld;
  logic [atan2op_pkg::Q_WIDTH-1:0]  sq_t;
  logic [atan2op_pkg::Q_WIDTH-1:0]  sq_t2;
  atan2op_pkg::ctrl_t               sq_ctl;
  logic [61:0]                      t_sq;

  assign t_sq = 62'(t) * 62'(t);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (en) begin
      sq_vld <= in_valid;
    end
    if (en) begin
      sq_t   <= t;
      sq_t2  <= atan2op_pkg::Q_WIDTH'((t_sq + 62'(atan2op_pkg::Q30_HALF)) >> 30);
      sq_ctl <= in_ctrl;
    end
  end

  logic                             vld [0:N-1];
  logic signed [31:0]               acc [0:N-1];
  logic [atan2op_pkg::Q_WIDTH-1:0]  tv  [0:N-1];
  logic [atan2op_pkg::Q_WIDTH-1:0]  t2v [0:N-1];
  atan2op_pkg::ctrl_t               ctl [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_horner
    logic signed [31:0]               r_in;
    logic [atan2op_pkg::Q_WIDTH-1:0]  t_in;
    logic [atan2op_pkg::Q_WIDTH-1:0]  t2_in;
    logic                             v_in;
    atan2op_pkg::ctrl_t               c_in;
    logic signed [31:0]               prod;

    if (k == 0) begin : g_first
      assign r_in  = atan2op_pkg::COEF_0;
      assign t_in  = sq_t;
      assign t2_in = sq_t2;
      assign v_in  = sq_vld;
      assign c_in  = sq_ctl;
    end else begin : g_next
      assign r_in  = acc[k-1];
      assign t_in  = tv[k-1];
      assign t2_in = t2v[k-1];
      assign v_in  = vld[k-1];
      assign c_in  = ctl[k-1];
    end

    if (k < N - 1) begin : g_t2
      assign prod = atan2op_pkg::mul_q30(r_in, t2_in) + atan2op_pkg::HORNER_ADD[k];
    end else begin : g_t
      assign prod = atan2op_pkg::mul_q30(r_in, t_in);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
      if (en) begin
        acc[k] <= prod;
        tv[k]  <= t_in;
        t2v[k] <= t2_in;
        ctl[k] <= c_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign r_out     = acc[N-1];
  assign out_ctrl  = ctl[N-1];

endmodule

### hw/rtl/atan2op_quad.sv
`timescale 1ns / 1ps
module atan2op_quad (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic signed [31:0]                          r_in,
  input  atan2op_pkg::ctrl_t                          in_ctrl,
  output logic                                        out_valid,
  output logic signed [atan2op_pkg::ANGLE_WIDTH-1:0]  angle
);

  localparam int unsigned A = atan2op_pkg::ACC_WIDTH;

  logic signed [A-1:0] r_ext;
  logic signed [A-1:0] r_oct;
  logic signed [A-1:0] r_map;

  assign r_ext = A'(r_in);
  assign r_oct = in_ctrl.flip ? atan2op_pkg::Q30_HALFPI - r_ext : r_ext;

  always_comb begin
    case ({in_ctrl.yneg, in_ctrl.xneg})
      2'b01:   r_map = atan2op_pkg::Q30_PI - r_oct;
      2'b10:   r_map = -r_oct;
      2'b11:   r_map = r_oct - atan2op_pkg::Q30_PI;
      default: r_map = r_oct;
    endcase
  end

  logic                m_vld;
  logic signed [A-1:0] m_r;
  atan2op_pkg::ctrl_t  m_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= in_valid;
    end
    if (en) begin
      m_r   <= r_map;
      m_ctl <= in_ctrl;
    end
  end

  // round to Q13, ties away from zero, then clamp to pi
  logic [A-2:0]                              mag_q30;
  logic [A-18:0]                             mag_q13;
  logic [atan2op_pkg::ANGLE_WIDTH-1:0]       mag_sat;
  logic signed [atan2op_pkg::ANGLE_WIDTH-1:0] rounded;

  assign mag_q30 = m_r[A-1] ? (A-1)'(-m_r) : (A-1)'(m_r);
  assign mag_q13 = (A-17)'((mag_q30 + (A-1)'(1 << 16)) >> 17);
  assign mag_sat = (mag_q13 > (A-17)'(atan2op_pkg::Q13_PI))
                   ? atan2op_pkg::Q13_PI
                   : atan2op_pkg::ANGLE_WIDTH'(mag_q13);
  assign rounded = m_r[A-1] ? -$signed(mag_sat) : $signed(mag_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_vld;
    end
    if (en) begin
      angle <= m_ctl.special ? m_ctl.special_angle : rounded;
    end
  end

endmodule

### hw/rtl/atan2_octant_polynomial.sv
`timescale 1ns / 1ps
// Four-quadrant arctangent: each transfer carries a signed (y, x) pair and
// yields atan2(y, x) as signed Q3.13 radians (pi = 25736). One pair is taken
// every cycle unless the output is stalled, in which case the whole pipeline
// holds. The stages, independent of COORD_WIDTH, are one input stage, 31
// divider stages (one quotient bit each), one squaring stage, nine Horner
// multiply stages, a quadrant stage and the rounding/output register.
// y = 0 gives 0 (x >= 0) or +pi; x = 0 gives +/-pi/2.
module atan2_octant_polynomial #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // y_value [COORD_WIDTH-1:0], x_value [2*COORD_WIDTH-1:COORD_WIDTH], zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // angle [15:0]
  output logic [atan2op_pkg::ANGLE_WIDTH-1:0]   m_axis_tdata
);

  localparam int unsigned W = COORD_WIDTH;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [W-1:0] y_raw, x_raw, y_mag, x_mag;
  logic         y_neg, x_neg, swap;

  assign y_raw = s_axis_tdata[W-1:0];
  assign x_raw = s_axis_tdata[2*W-1:W];
  assign y_neg = y_raw[W-1];
  assign x_neg = x_raw[W-1];
  assign y_mag = y_neg ? W'(-y_raw) : y_raw;
  assign x_mag = x_neg ? W'(-x_raw) : x_raw;
  assign swap  = x_mag < y_mag;

  atan2op_pkg::ctrl_t ctrl_next;

  always_comb begin
    ctrl_next.yneg          = y_neg;
    ctrl_next.xneg          = x_neg;
    ctrl_next.flip          = swap;
    ctrl_next.special       = (y_raw == '0) || (x_raw == '0);
    if (y_raw == '0) begin
      ctrl_next.special_angle = x_neg ? atan2op_pkg::Q13_PI : '0;
    end else begin
      ctrl_next.special_angle = y_neg ? -atan2op_pkg::Q13_HALFPI : atan2op_pkg::Q13_HALFPI;
    end
  end

  logic               in_vld;
  logic [W-1:0]       in_lo, in_hi;
  atan2op_pkg::ctrl_t in_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= s_axis_tvalid;
    end
    if (en) begin
      in_lo  <= swap ? x_mag : y_mag;
      in_hi  <= swap ? y_mag : x_mag;
      in_ctl <= ctrl_next;
    end
  end

  logic                             div_vld;
  logic [atan2op_pkg::Q_WIDTH-1:0]  div_t;
  atan2op_pkg::ctrl_t               div_ctl;

  atan2op_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_vld),
    .lo        (in_lo),
    .hi        (in_hi),
    .in_ctrl   (in_ctl),
    .out_valid (div_vld),
    .quo_out   (div_t),
    .out_ctrl  (div_ctl)
  );

  logic               poly_vld;
  logic signed [31:0] poly_r;
  atan2op_pkg::ctrl_t poly_ctl;

  atan2op_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_vld),
    .t         (div_t),
    .in_ctrl   (div_ctl),
    .out_valid (poly_vld),
    .r_out     (poly_r),
    .out_ctrl  (poly_ctl)
  );

  logic signed [atan2op_pkg::ANGLE_WIDTH-1:0] angle;

  atan2op_quad u_quad (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (poly_vld),
    .r_in      (poly_r),
    .in_ctrl   (poly_ctl),
    .out_valid (m_axis_tvalid),
    .angle     (angle)
  );

  assign m_axis_tdata = angle;

endmodule

### verif/atan2_octant_polynomial_tb.sv
`timescale 1ns / 1ps
module atan2_octant_polynomial_tb;

  localparam int CW = 16;
  localparam int DW = ((2*CW+7)/8)*8;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALFPI_Q30 = 64'sd1686629713;
  localparam longint PI_Q13 = 25736;
  localparam longint HALFPI_Q13 = 12868;

  // multiply signed Q30 by unsigned Q30, round half away from zero
  function automatic longint q30_product(longint r, longint u);
    longint a;
    longint p;
    a = (r < 0) ? -r : r;
    p = (a * u + 64'sd536870912) >>> 30;
    return (r < 0) ? -p : p;
  endfunction

  function automatic logic [15:0] angle_of(logic [CW-1:0] yv, logic [CW-1:0] xv);
    longint coef [0:7];
    longint ym, xm, lo, hi, t, t2, r, a, mag;
    bit yneg, xneg, flip;
    coef = '{3077586, 17357828, 46073848, 80841632,
             114420760, 152566896, 214679120, 357911936};
    yneg = yv[CW-1];
    xneg = xv[CW-1];
    ym = yneg ? longint'(CW'(-yv)) : longint'(yv);
    xm = xneg ? longint'(CW'(-xv)) : longint'(xv);
    if (ym == 0) return xneg ? 16'(PI_Q13) : 16'd0;
    if (xm == 0) return yneg ? 16'(-HALFPI_Q13) : 16'(HALFPI_Q13);
    flip = xm < ym;
    lo = flip ? xm : ym;
    hi = flip ? ym : xm;
    t = (lo <<< 30) / hi;
    t2 = (t * t + 64'sd536870912) >>> 30;
    r = coef[0];
    r = q30_product(r, t2) - coef[1];
    r = q30_product(r, t2) + coef[2];
    r = q30_product(r, t2) - coef[3];
    r = q30_product(r, t2) + coef[4];
    r = q30_product(r, t2) - coef[5];
    r = q30_product(r, t2) + coef[6];
    r = q30_product(r, t2) - coef[7];
    r = q30_product(r, t2) + ONE_Q30;
    r = q30_product(r, t);
    if (flip) r = HALFPI_Q30 - r;
    if (!yneg && xneg) r = PI_Q30 - r;
    else if (yneg && !xneg) r = -r;
    else if (yneg && xneg) r = r - PI_Q30;
    a = (r < 0) ? -r : r;
    mag = (a + 65536) >>> 17;
    if (mag > PI_Q13) mag = PI_Q13;
    return (r < 0) ? 16'(-mag) : 16'(mag);
  endfunction

  class angle_scoreboard;
    logic [15:0] pending_angles[$];
    int mismatches;

    function void note_pair(logic [CW-1:0] yv, logic [CW-1:0] xv);
      pending_angles.push_back(angle_of(yv, xv));
    endfunction

    function void check_angle(logic [15:0] got);
      logic [15:0] want;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected angle transfer %0d", $signed(got));
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("angle mismatch: expected %0d got %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;

  angle_scoreboard sb = new();
  int send_idle_pct = 7;
  int recv_idle_pct = 64;
  bit hold_off = 0;

  always #1 clk = ~clk;

  atan2_octant_polynomial #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // sample transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pair(s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW]);
      if (m_axis_tvalid && m_axis_tready) sb.check_angle(m_axis_tdata);
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pair(logic [CW-1:0] yv, logic [CW-1:0] xv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {xv, yv};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] random_coord();
    case ($urandom_range(5))
      0: return CW'($urandom_range(7)) - CW'(4);
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [CW-1:0] yv;
    for (int i = 0; i < count; i++) begin
      yv = random_coord();
      // equal magnitudes exercise the octant boundary
      if ($urandom_range(19) == 0) send_pair(yv, $urandom_range(1) ? yv : -yv);
      else send_pair(yv, random_coord());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [CW-1:0] edge_vals [0:5];
    edge_vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (edge_vals[i]) begin
      send_pair(edge_vals[i], edge_vals[(i + 3) % 6]);
      send_pair(edge_vals[i], edge_vals[(i + 1) % 6]);
      send_pair(edge_vals[i], edge_vals[i]);
    end
    send_pair(16'd3, 16'd7);
    send_pair(16'd7, 16'hFFFD);
    // hold the output off long enough for the pipeline to fill
    hold_off = 1;
    fork
      repeat (200) @(negedge clk);
      random_phase(100);
    join_any
    hold_off = 0;
    wait fork;
    random_phase(600);
    send_idle_pct = 64;
    recv_idle_pct = 7;
    random_phase(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600);
    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_angles.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/atan2op_pkg.sv
hw/rtl/atan2op_div.sv
hw/rtl/atan2op_poly.sv
hw/rtl/atan2op_quad.sv
hw/rtl/atan2_octant_polynomial.sv
verif/atan2_octant_polynomial_tb.sv
